[hw/rtl/pbosc_pkg.sv]
`timescale 1ns / 1ps
package pbosc_pkg;

    localparam int unsigned SINE_TABLE_DEPTH = 256;
    localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned PHASE_BITS       = 32;
    localparam int unsigned QUEUE_DEPTH_DEF  = 2;

    localparam logic [31:0] PHASE_MASK =
        32'(~((64'd1 << (32 - PHASE_BITS)) - 64'd1));
    localparam logic [31:0] PHASE_HALF    = 32'h8000_0000;
    localparam logic [30:0] HPI_Q30       = 31'd1686629713;
    localparam logic [30:0] INC_RESET     = 31'd39370534;
    localparam int unsigned DIV_STEPS     = 30;

    // Half-step angle denominator for the table build: two per entry.
    localparam logic [63:0] SINE_ANGLE_DEN = 64'(2 * SINE_TABLE_DEPTH);

    typedef enum logic [1:0] {
        MODE_SINE     = 2'd0,
        MODE_SAW      = 2'd1,
        MODE_SQUARE   = 2'd2,
        MODE_TRIANGLE = 2'd3
    } wave_mode_t;

    typedef enum logic [0:0] {
        REG_PHASE_INCREMENT = 1'b0,
        REG_WAVE_MODE       = 1'b1
    } reg_index_t;

    typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    // Quarter-wave table, entry i = sin(pi/2 * (i + 1/2) / depth) in Q15,
    // from a Taylor series in Q30.
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            a    = 64'(HPI_Q30) * (64'(2 * i) + 64'd1) / SINE_ANGLE_DEN;
            a2   = (a * a) >> 30;
            term = a;
            sum  = a;
            term = ((term * a2) >> 30) / 64'd6;
            sum  = sum - term;
            term = ((term * a2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * a2) >> 30) / 64'd42;
            sum  = sum - term;
            term = ((term * a2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * a2) >> 30) / 64'd110;
            sum  = sum - term;
            rom[i] = 16'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[hw/rtl/pbosc_if.sv]
`timescale 1ns / 1ps
interface pbosc_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] sample_time;
    logic [31:0] phase_offset;

    modport source (output valid, output kind, output sample_time, output phase_offset,
                    input ready);
    modport sink (input valid, input kind, input sample_time, input phase_offset,
                  output ready);
endinterface

interface pbosc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface pbosc_phase_if;
    logic        valid;
    logic        ready;
    logic [31:0] phase;

    modport source (output valid, output phase, input ready);
    modport sink (input valid, input phase, output ready);
endinterface

[hw/rtl/pbosc_front.sv]
`timescale 1ns / 1ps
module pbosc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [30:0]         inc,
    pbosc_req_if.sink           request,
    pbosc_phase_if.source       phase
);
    import pbosc_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_PUSH = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [31:0]  acc_reg, acc_next;
    logic [31:0]  offset_reg, offset_next;
    logic [31:0]  timed;
    logic         take;

    assign timed         = request.sample_time * {1'b0, inc};
    assign request.ready = (state_reg == F_IDLE);
    assign take          = request.valid && request.ready;
    assign phase.valid   = (state_reg == F_PUSH);
    assign phase.phase   = (acc_reg + offset_reg) & PHASE_MASK;

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        offset_next = offset_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    acc_next    = (request.kind ? timed : acc_reg + {1'b0, inc}) & PHASE_MASK;
                    offset_next = request.phase_offset;
                    state_next  = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (phase.ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
    end

    // The accumulator moves only when an item comes in.
    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(take) |-> $stable(acc_reg))
        else $error("phase accumulator moved without an item");

endmodule

[hw/rtl/pbosc_queue.sv]
`timescale 1ns / 1ps
module pbosc_queue #(
    parameter int unsigned DEPTH = pbosc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pbosc_phase_if.sink   push,
    pbosc_phase_if.source pop
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [31:0]      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push.ready = (count_reg < CNT_W'(DEPTH));
    assign pop.valid  = (count_reg != '0);
    assign pop.phase  = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && push.ready;
    assign do_pop     = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.phase;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");

endmodule

[hw/rtl/pbosc_back.sv]
`timescale 1ns / 1ps
module pbosc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [30:0]           inc,
    input  pbosc_pkg::wave_mode_t mode,
    pbosc_phase_if.sink           phase,
    pbosc_out_if.source           sample
);
    import pbosc_pkg::*;

    typedef enum logic [13:0] {
        B_IDLE    = 14'b00000000000001,
        B_SINE    = 14'b00000000000010,
        B_SETUP   = 14'b00000000000100,
        B_CHECK   = 14'b00000000001000,
        B_DIV     = 14'b00000000010000,
        B_SQUARE  = 14'b00000000100000,
        B_ACCUM   = 14'b00000001000000,
        B_COEF    = 14'b00000010000000,
        B_DIFF    = 14'b00000100000000,
        B_MUL_LO  = 14'b00001000000000,
        B_MUL_HI  = 14'b00010000000000,
        B_INTEG   = 14'b00100000000000,
        B_ROUND   = 14'b01000000000000,
        B_OUT     = 14'b10000000000000
    } back_state_t;

    localparam logic signed [34:0] V_ONE = 35'sd1073741824;

    back_state_t          state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          out_data_reg, out_data_next;
    logic signed [31:0]   y_reg, y_next;
    logic [31:0]          p_reg, p_next;
    logic signed [34:0]   v_reg, v_next;
    logic                 sel_reg, sel_next;
    logic                 neg_reg, neg_next;
    logic [30:0]          rem_reg, rem_next;
    logic [29:0]          quo_reg, quo_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [61:0]          mul_reg, mul_next;
    logic [25:0]          a_reg, a_next;
    logic signed [35:0]   diff_reg, diff_next;
    logic [43:0]          lo_reg, lo_next;
    logic signed [44:0]   hi_reg, hi_next;
    logic [15:0]          res_reg, res_next;

    logic [SINE_IDX_W-1:0] sine_idx;
    logic [15:0]           sine_mag;
    logic [31:0]           t;
    logic [32:0]           lim;
    logic [32:0]           wrap_gap;
    logic [31:0]           shifted;
    logic                  fits;
    logic [30:0]           w;
    logic [61:0]           sq_round;
    logic [30:0]           s;
    logic                  flip;
    logic                  last_blep;
    back_state_t           after_blep;
    logic [61:0]           coef_sum;
    logic signed [63:0]    total;
    logic signed [39:0]    upd;
    logic signed [40:0]    ysum;
    logic signed [31:0]    ysat;
    logic signed [35:0]    rsum;
    logic signed [20:0]    rq;

    assign sine_idx = p_reg[30] ? ~p_reg[29 -: SINE_IDX_W] : p_reg[29 -: SINE_IDX_W];
    assign sine_mag = SINE_ROM[sine_idx];

    assign t        = sel_reg ? p_reg + PHASE_HALF : p_reg;
    assign lim      = 33'h1_0000_0000 - {2'b00, inc};
    assign wrap_gap = 33'h1_0000_0000 - {1'b0, t};
    assign shifted  = {rem_reg, 1'b0};
    assign fits     = (shifted >= {1'b0, inc});

    assign w        = (31'd1 << 30) - {1'b0, quo_reg};
    assign sq_round = mul_reg + (62'd1 << 29);
    assign s        = sq_round[60:30];
    assign flip     = (mode == MODE_SAW) || sel_reg;

    assign last_blep  = (mode == MODE_SAW) || sel_reg;
    assign after_blep = (mode == MODE_TRIANGLE) ? B_COEF : B_ROUND;

    assign coef_sum = mul_reg + (62'd1 << 35);
    assign total    = (64'(hi_reg) <<< 18) + $signed({20'b0, lo_reg}) + 64'sd8388608;
    assign upd      = total[63:24];
    assign ysum     = $signed({upd[39], upd}) + 41'(y_reg);
    assign ysat     = ((ysum[40:31] == '0) || (ysum[40:31] == '1)) ? ysum[31:0]
                    : (ysum[40] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign rsum = $signed({v_reg[34], v_reg}) + 36'sd16384;
    assign rq   = rsum[35:15];

    assign phase.ready         = (state_reg == B_IDLE);
    assign sample.valid        = out_valid_reg;
    assign sample.sample_value = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !sample.ready;
        out_data_next  = out_data_reg;
        y_next         = y_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        sel_next       = sel_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        mul_next       = mul_reg;
        a_next         = a_reg;
        diff_next      = diff_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_next       = res_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (phase.valid)
                begin
                    p_next     = phase.phase;
                    state_next = (mode == MODE_SINE) ? B_SINE : B_SETUP;
                end
            end
            B_SINE:
            begin
                res_next   = p_reg[31] ? 16'(16'd0 - sine_mag) : sine_mag;
                state_next = B_OUT;
            end
            B_SETUP:
            begin
                if (mode == MODE_SAW)
                begin
                    v_next = $signed({4'b0, p_reg[31:1]}) - V_ONE;
                end
                else
                begin
                    v_next = p_reg[31] ? -V_ONE : V_ONE;
                end
                sel_next   = 1'b0;
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                quo_next = '0;
                cnt_next = 5'(DIV_STEPS - 1);
                if (t < {1'b0, inc})
                begin
                    rem_next   = t[30:0];
                    neg_next   = 1'b1;
                    state_next = B_DIV;
                end
                else if ({1'b0, t} > lim)
                begin
                    rem_next   = wrap_gap[30:0];
                    neg_next   = 1'b0;
                    state_next = B_DIV;
                end
                else if (last_blep)
                begin
                    state_next = after_blep;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = B_CHECK;
                end
            end
            B_DIV:
            begin
                // One quotient bit a cycle; remainder stays below the increment.
                rem_next = fits ? 31'(shifted - {1'b0, inc}) : shifted[30:0];
                quo_next = {quo_reg[28:0], fits};
                if (cnt_reg == '0)
                begin
                    state_next = B_SQUARE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            B_SQUARE:
            begin
                mul_next   = 62'(w) * 62'(w);
                state_next = B_ACCUM;
            end
            B_ACCUM:
            begin
                if (neg_reg ^ flip)
                begin
                    v_next = v_reg - $signed({4'b0, s});
                end
                else
                begin
                    v_next = v_reg + $signed({4'b0, s});
                end
                if (last_blep)
                begin
                    state_next = after_blep;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = B_CHECK;
                end
            end
            B_COEF:
            begin
                mul_next   = 62'(inc) * 62'(HPI_Q30);
                state_next = B_DIFF;
            end
            B_DIFF:
            begin
                a_next     = coef_sum[61:36];
                diff_next  = $signed({v_reg[34], v_reg}) - 36'(y_reg);
                state_next = B_MUL_LO;
            end
            B_MUL_LO:
            begin
                lo_next    = 44'(a_reg) * 44'(diff_reg[17:0]);
                state_next = B_MUL_HI;
            end
            B_MUL_HI:
            begin
                hi_next    = $signed({1'b0, a_reg}) * $signed(diff_reg[35:18]);
                state_next = B_INTEG;
            end
            B_INTEG:
            begin
                y_next     = ysat;
                v_next     = 35'(ysat);
                state_next = B_ROUND;
            end
            B_ROUND:
            begin
                if ((rq[20:15] == '0) || (rq[20:15] == '1))
                begin
                    res_next = rq[15:0];
                end
                else
                begin
                    res_next = rq[20] ? 16'h8000 : 16'h7FFF;
                end
                state_next = B_OUT;
            end
            B_OUT:
            begin
                // Load the output register once it is free or being drained.
                if (!out_valid_reg || sample.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            y_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            y_reg         <= y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        p_reg        <= p_next;
        v_reg        <= v_next;
        sel_reg      <= sel_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        mul_reg      <= mul_next;
        a_reg        <= a_next;
        diff_reg     <= diff_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        res_reg      <= res_next;
    end

    a_rem_below_inc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> {1'b0, rem_reg} < {1'b0, inc})
        else $error("divider remainder reached the increment");

    a_integ_mode: assert property (@(posedge clk) disable iff (!rst_n)
        y_reg != $past(y_reg) |-> $past(mode) == MODE_TRIANGLE)
        else $error("integrator moved outside triangle mode");

endmodule

[hw/rtl/polyblep_oscillator.sv]
`timescale 1ns / 1ps
// Channel   Dir   Payload                              Transfer
// request   in    kind, sample_time, phase_offset     valid && ready
// sample    out   sample_value (signed Q1.15)         valid && ready
// cfg       in    cfg_index, cfg_data                 cfg_write
//
// The front takes an item and queues the phase; the back reads sine from the
// table, and for saw, square and triangle runs the radix-2 divider once per
// PolyBLEP edge.
// Reset clears the phase accumulator, integrator, queue and output valid.
// A stalled output holds its item; the front accepts until the queue fills.
module polyblep_oscillator #(
    parameter int unsigned QUEUE_DEPTH = pbosc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  pbosc_pkg::reg_index_t cfg_index,
    input  logic [30:0]           cfg_data,
    pbosc_req_if.sink             request,
    pbosc_out_if.source           sample
);
    import pbosc_pkg::*;

    logic [30:0] inc_reg;
    wave_mode_t  mode_reg;

    pbosc_phase_if front_q ();
    pbosc_phase_if q_back ();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg  <= INC_RESET;
            mode_reg <= MODE_SINE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PHASE_INCREMENT: inc_reg  <= cfg_data;
                REG_WAVE_MODE:       mode_reg <= wave_mode_t'(cfg_data[1:0]);
                default:             inc_reg  <= inc_reg;
            endcase
        end
    end

    pbosc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .inc     (inc_reg),
        .request (request),
        .phase   (front_q.source)
    );

    pbosc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_q.sink),
        .pop   (q_back.source)
    );

    pbosc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .inc    (inc_reg),
        .mode   (mode_reg),
        .phase  (q_back.sink),
        .sample (sample)
    );

endmodule

[tb/pbosc_tb_if.sv]
`timescale 1ns / 1ps
// The block's channel interfaces live with the RTL; this file only carries the
// request item record used by the bench.
package pbosc_tb_pkg;

    typedef struct packed {
        logic        kind;
        logic [31:0] sample_time;
        logic [31:0] phase_offset;
    } osc_item_t;

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import pbosc_pkg::*;
    import pbosc_tb_pkg::*;

    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam int     N_RANDOM = 1500;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    reg_index_t          cfg_index;
    logic [30:0]         cfg_data;

    pbosc_req_if request();
    pbosc_out_if sample();

    polyblep_oscillator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request.sink),
        .sample    (sample.source)
    );

    // predictor state
    logic [15:0]  sine_lut [SINE_TABLE_DEPTH];
    logic [31:0]  model_phase;
    logic signed [31:0] model_integ;
    logic [30:0]  model_inc;
    wave_mode_t   model_mode;

    logic [15:0]  expected_samples [$];
    int           failures;
    int           hold_cycles;

    // directed rows; has_gold marks a typed-in expectation
    typedef struct {
        osc_item_t   item;
        bit          has_gold;
        logic [15:0] gold;
    } dir_row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint poly_step(logic [31:0] t, logic [30:0] inc);
        logic [63:0] w;
        logic [63:0] d;
        if (inc == 0)
            return 0;
        if (t < {1'b0, inc})
        begin
            w = 64'(ONE_Q30) - ((64'(t) << 30) / 64'(inc));
            return -longint'((w * w + (64'd1 << 29)) >> 30);
        end
        if (64'(t) > (64'd1 << 32) - 64'(inc))
        begin
            d = (64'd1 << 32) - 64'(t);
            w = 64'(ONE_Q30) - ((d << 30) / 64'(inc));
            return longint'((w * w + (64'd1 << 29)) >> 30);
        end
        return 0;
    endfunction

    function automatic void fill_sine_lut();
        logic [63:0] a, a2, term, sum;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            a    = 64'd1686629713 * (2 * i + 1) / (2 * SINE_TABLE_DEPTH);
            a2   = (a * a) >> 30;
            term = a;
            sum  = a;
            for (int k = 1; k <= 5; k++)
            begin
                term = ((term * a2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
                sum  = (k % 2) ? sum - term : sum + term;
            end
            sine_lut[i] = 16'((sum * 32767 + (64'd1 << 29)) >> 30);
        end
    endfunction

    function automatic logic [15:0] next_sample(osc_item_t it);
        logic [31:0] p;
        logic [31:0] q_idx;
        longint      v, y, a, r;
        if (it.kind)
            model_phase = it.sample_time * {1'b0, model_inc};
        else
            model_phase = model_phase + {1'b0, model_inc};
        model_phase &= PHASE_MASK;
        p = (model_phase + it.phase_offset) & PHASE_MASK;
        if (model_mode == MODE_SINE)
        begin
            q_idx = 32'((64'(p[29:0]) * SINE_TABLE_DEPTH) >> 30);
            if (p[30])
                q_idx = SINE_TABLE_DEPTH - 1 - q_idx;
            v = sine_lut[q_idx];
            return p[31] ? 16'(-v) : 16'(v);
        end
        if (model_mode == MODE_SAW)
            v = longint'(p >> 1) - ONE_Q30 - poly_step(p, model_inc);
        else
        begin
            v = p[31] ? -ONE_Q30 : ONE_Q30;
            v += poly_step(p, model_inc);
            v -= poly_step(p + PHASE_HALF, model_inc);
            if (model_mode == MODE_TRIANGLE)
            begin
                a = longint'((64'(model_inc) * 64'd1686629713 + (64'd1 << 35)) >> 36);
                y = model_integ;
                y += floor_sh(a * (v - y) + (64'sd1 << 23), 24);
                if (y > 64'sd2147483647)
                    y = 64'sd2147483647;
                if (y < -64'sd2147483648)
                    y = -64'sd2147483648;
                model_integ = 32'(y);
                v = y;
            end
        end
        r = floor_sh(v + (64'sd1 << 14), 15);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return 16'(r);
    endfunction

    task automatic write_reg(reg_index_t idx, logic [30:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_PHASE_INCREMENT)
            model_inc = val;
        else
            model_mode = wave_mode_t'(val[1:0]);
    endtask

    // drain everything, then cover the back end's longest pass
    task automatic wait_idle();
        int guard;
        guard = 0;
        request.valid <= 1'b0;
        while (expected_samples.size() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
    endtask

    // valid stays up after a handshake; drop it only when idling first
    task automatic send_item(osc_item_t it, bit has_gold, logic [15:0] gold);
        logic [15:0] pred;
        int          gap;
        gap = $urandom_range(0, 9);
        if (gap != 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request.valid        <= 1'b1;
        request.kind         <= it.kind;
        request.sample_time  <= it.sample_time;
        request.phase_offset <= it.phase_offset;
        do
            @(posedge clk);
        while (!request.ready);
        pred = next_sample(it);
        if (has_gold && gold != pred)
            $display("%0t: directed row disagrees with predictor: typed %0d, predicted %0d",
                     $time, $signed(gold), $signed(pred));
        expected_samples.push_back(has_gold ? gold : pred);
    endtask

    function automatic osc_item_t rand_item();
        osc_item_t it;
        it.kind         = ($urandom_range(0, 3) == 0);
        it.sample_time  = $urandom();
        it.phase_offset = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
        return it;
    endfunction

    // output side: random stall plus one long hold-off
    initial
    begin
        sample.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                sample.ready <= 1'b0;
                hold_cycles--;
            end
            else if (sample.ready && sample.valid)
                sample.ready <= ($urandom_range(0, 2) == 0) ? 1'b1 : 1'b0;
            else
                sample.ready <= ($urandom_range(0, 9) < 4) ? 1'b1 : 1'b0;
        end
    end

    // compare accepted samples
    always @(posedge clk)
    begin
        if (rst_n && sample.valid && sample.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample %0d", $time, $signed(sample.sample_value));
                failures++;
            end
            else
            begin
                if (sample.sample_value !== expected_samples[0])
                begin
                    $display("%0t: sample_value expected %0d actual %0d", $time,
                             $signed(expected_samples[0]), $signed(sample.sample_value));
                    failures++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    initial
    begin
        dir_row_t    rows [$];
        osc_item_t   it;
        logic [30:0] inc_set [6];
        int          guard;

        failures             = 0;
        hold_cycles          = 0;
        rst_n                = 1'b0;
        cfg_write            = 1'b0;
        cfg_index            = REG_PHASE_INCREMENT;
        cfg_data             = '0;
        request.valid        = 1'b0;
        request.kind         = 1'b0;
        request.sample_time  = '0;
        request.phase_offset = '0;
        fill_sine_lut();
        model_phase = '0;
        model_integ = '0;
        model_inc   = INC_RESET;
        model_mode  = MODE_SINE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sine after reset: timed sample at zero lands on the first table entry,
        // quarter offsets walk all four quadrants
        rows.push_back('{'{1'b1, 32'd0, 32'd0}, 1'b0, 16'd0});
        rows.push_back('{'{1'b1, 32'd0, 32'h4000_0000}, 1'b0, 16'd0});
        rows.push_back('{'{1'b1, 32'd0, 32'h8000_0000}, 1'b0, 16'd0});
        rows.push_back('{'{1'b1, 32'd0, 32'hC000_0000}, 1'b0, 16'd0});
        rows.push_back('{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 16'd0});
        rows.push_back('{'{1'b0, 32'd0, 32'd0}, 1'b0, 16'd0});
        rows.push_back('{'{1'b0, 32'hFFFF_FFFF, 32'h3FFF_FFFF}, 1'b0, 16'd0});
        foreach (rows[i])
            send_item(rows[i].item, rows[i].has_gold, rows[i].gold);
        wait_idle();

        // saw: phase 0 with zero offset sits right on the jump
        write_reg(REG_WAVE_MODE, 31'(MODE_SAW));
        send_item('{1'b1, 32'd0, 32'd0}, 1'b0, 16'd0);
        send_item('{1'b1, 32'd0, 32'h7FFF_FFFF}, 1'b0, 16'd0);
        send_item('{1'b1, 32'd0, 32'hFFFF_FFFF}, 1'b0, 16'd0);
        wait_idle();
        // square, then triangle with the widest increment so the integrator saturates
        write_reg(REG_WAVE_MODE, 31'(MODE_SQUARE));
        send_item('{1'b1, 32'd0, 32'h4000_0000}, 1'b1, 16'h7FFF);
        send_item('{1'b1, 32'd0, 32'hC000_0000}, 1'b1, 16'h8000);
        send_item('{1'b1, 32'd0, 32'h8000_0000}, 1'b0, 16'd0);
        wait_idle();
        write_reg(REG_PHASE_INCREMENT, 31'h7FFF_FFFF);
        write_reg(REG_WAVE_MODE, 31'(MODE_TRIANGLE));
        for (int i = 0; i < 6; i++)
            send_item('{1'b0, 32'd0, 32'(i) << 29}, 1'b0, 16'd0);
        wait_idle();
        // zero increment: no correction and the integrator holds
        write_reg(REG_PHASE_INCREMENT, 31'd0);
        send_item('{1'b0, 32'd5, 32'h1234_5678}, 1'b0, 16'd0);
        send_item('{1'b1, 32'd9, 32'h8000_0000}, 1'b0, 16'd0);
        wait_idle();

        inc_set = '{31'd1, 31'd39370534, 31'h7FFF_FFFF, 31'd0, 31'h0100_0000, 31'h2000_0000};
        for (int phase_n = 0; phase_n < 12; phase_n++)
        begin
            write_reg(REG_PHASE_INCREMENT, (phase_n % 4 == 3) ? 31'($urandom()) :
                      inc_set[phase_n % 6]);
            write_reg(REG_WAVE_MODE, 31'($urandom_range(0, 3)));
            for (int n = 0; n < N_RANDOM / 12; n++)
            begin
                if (phase_n == 4 && n == 10)
                    hold_cycles = 2000;
                if (phase_n == 7 && n == 20)
                begin
                    // pause the sender until every result is back
                    request.valid <= 1'b0;
                    guard = 0;
                    do
                    begin
                        @(posedge clk);
                        guard++;
                    end
                    while (expected_samples.size() != 0 && guard < 200_000);
                end
                it = rand_item();
                send_item(it, 1'b0, 16'd0);
            end
            wait_idle();
        end

        if (failures == 0 && expected_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            if (expected_samples.size() != 0)
                $display("%0t: %0d samples never arrived", $time, expected_samples.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
